// ----- rtl/nmea_position_sentence_parser_core_defines.svh -----
// Assertion macros shared by the sentence parser RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef NMEA_POSITION_SENTENCE_PARSER_CORE_DEFINES_SVH
`define NMEA_POSITION_SENTENCE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NMPS_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NMPS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/nmps_pkg.sv -----
// Types, constants and helper functions for the NMEA position sentence parser.
// Used by the line parser, the result register and the top level.
package nmps_pkg;

  localparam int MAX_LINE_LENGTH = 128;
  localparam int LINE_POS_W      = $clog2(MAX_LINE_LENGTH + 2);
  localparam logic [LINE_POS_W-1:0] LINE_POS_MAX = LINE_POS_W'(MAX_LINE_LENGTH);
  localparam logic [LINE_POS_W-1:0] HEAD_LEN     = LINE_POS_W'(6);

  localparam int DATA_W = 184;
  localparam int USER_W = 2;
  localparam int INT_W  = 25;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_R     = "R";
  localparam logic [7:0] CH_G     = "G";
  localparam logic [7:0] CH_N     = "N";
  localparam logic [7:0] CH_S     = "S";
  localparam logic [7:0] CH_E     = "E";
  localparam logic [7:0] CH_W     = "W";
  localparam logic [7:0] CH_F     = "F";

  // Integer part saturates here; every consumer caps well below it.
  localparam logic [INT_W-1:0] INT_CAP    = 25'd16777216;
  localparam logic [33:0]      ANGLE_MAX  = 34'd6000000000;
  localparam logic [33:0]      ANGLE_SAT  = 34'd6000000001;
  localparam logic [23:0]      SPD_MAX    = 24'd9999999;
  localparam logic [19:0]      DATE_MAX   = 20'd999999;
  localparam logic [23:0]      ALT_POS    = 24'h7FFFFF;
  localparam logic [23:0]      ALT_NEG    = 24'h800000;

  localparam logic [1:0] STAR_DONE = 2'd2;
  localparam logic [1:0] STAR_BAD  = 2'd3;
  localparam logic [3:0] PAIR_NONE = 4'd15;
  localparam logic [4:0] FIELD_LAST = 5'd31;
  localparam logic [3:0] DBP_LAST   = 4'd15;
  localparam logic [2:0] LEN_LAST   = 3'd7;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_RMC   = 2'd1,
    KIND_GGA   = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  typedef struct packed {
    logic [LINE_POS_W-1:0] line_pos;
    kind_t                 kind;
    logic [4:0]            field_num;
    logic [7:0]            xor_acc;
    logic [1:0]            star_digits;
    logic [7:0]            chk_rx;
    logic                  star_seen;
    logic [INT_W-1:0]      int_digits;
    logic [33:0]           deg_part;     // (integer / 100) * 600000, saturated
    logic [6:0]            min_part;     // integer % 100
    logic [13:0]           frac_digits;
    logic [2:0]            frac_count;
    logic [6:0]            frac_hund;    // first two fraction digits
    logic [3:0]            dbp;
    logic                  point_seen;
    logic                  negative;
    logic                  stopped;
    logic [7:0]            first_char;
    logic [2:0]            field_len;
    logic [3:0]            pair_first;
    logic [18:0]           time_val;
    logic [19:0]           date_val;
    logic signed [33:0]    lat_val;
    logic signed [33:0]    lon_val;
    logic signed [23:0]    alt_val;
    logic [23:0]           speed_val;
    logic [23:0]           course_val;
    logic [2:0]            valid_flags;
  } line_state_t;

  typedef struct packed {
    logic [1:0]         sentence_type;
    logic               checksum_ok;
    logic [18:0]        time_of_day_s;
    logic [19:0]        date_ddmmyy;
    logic signed [33:0] latitude;
    logic signed [33:0] longitude;
    logic signed [23:0] altitude_dm;
    logic [23:0]        speed_centiknots;
    logic [23:0]        course_centideg;
    logic               lat_valid;
    logic               lon_valid;
    logic               alt_valid;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9")      r = {1'b1, c[3:0]};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'd55)};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'd87)};
    return r;
  endfunction

  function automatic logic [7:0] head_rmc(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = "$";
      3'd1:    r = "G";
      3'd2:    r = "P";
      3'd3:    r = "R";
      3'd4:    r = "M";
      default: r = "C";
    endcase
    return r;
  endfunction

  function automatic logic [7:0] head_gga(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = "$";
      3'd1:    r = "G";
      3'd2:    r = "P";
      3'd3:    r = "G";
      3'd4:    r = "G";
      default: r = "A";
    endcase
    return r;
  endfunction

  // Fraction scaled to four digits, truncated.
  function automatic logic [13:0] frac4(input logic [13:0] fd, input logic [2:0] fc);
    logic [13:0] r;
    case (fc)
      3'd0:    r = 14'd0;
      3'd1:    r = 14'(fd * 14'd1000);
      3'd2:    r = 14'(fd * 14'd100);
      3'd3:    r = 14'(fd * 14'd10);
      default: r = fd;
    endcase
    return r;
  endfunction

  // Quotient by 100 for values up to 999.
  function automatic logic [3:0] div100(input logic [9:0] t);
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (t >= 10'(k * 100)) q = 4'(k);
    end
    return q;
  endfunction

  function automatic line_state_t field_clear(input line_state_t s);
    line_state_t r;
    r             = s;
    r.int_digits  = '0;
    r.deg_part    = '0;
    r.min_part    = '0;
    r.frac_digits = '0;
    r.frac_count  = '0;
    r.frac_hund   = '0;
    r.dbp         = '0;
    r.point_seen  = 1'b0;
    r.negative    = 1'b0;
    r.stopped     = 1'b0;
    r.first_char  = '0;
    r.field_len   = '0;
    r.pair_first  = PAIR_NONE;
    return r;
  endfunction

  function automatic line_state_t line_clear();
    line_state_t r;
    r = '0;
    return field_clear(r);
  endfunction

endpackage

// ----- rtl/nmps_line_parser.sv -----
// Per-byte line parser: holds the line and field state and builds one result
// at each newline. Depends on nmps_pkg.
module nmps_line_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output nmps_pkg::result_t res
);
  import nmps_pkg::*;

  line_state_t st;
  line_state_t st_next;
  kind_t       kind_next;

  // end-of-field results
  logic signed [33:0] ef_lat, ef_lon;
  logic signed [23:0] ef_alt;
  logic [23:0]        ef_speed, ef_course;
  logic [19:0]        ef_date;
  logic [2:0]         ef_flags;

  logic        full;
  logic [4:0]  base;
  logic [34:0] angle_sum;
  logic [33:0] angle_val;
  logic        angle_ok;
  logic [6:0]  hund_frac;
  logic [23:0] hund_val;
  logic signed [25:0] alt_int;
  logic signed [23:0] alt_int_sat;
  logic signed [27:0] alt_ext, alt_k, alt_mul;
  logic signed [23:0] alt_mul_sat;

  // field character path
  logic        dig;
  logic [3:0]  dval;
  logic [18:0] pair_w;
  logic [28:0] int_prod;
  logic [9:0]  min_t;
  logic [3:0]  carry;
  logic [36:0] deg_prod;
  logic [4:0]  hex;

  // result path
  logic        type_ok;
  logic        chk_ok;
  logic [4:0]  rbase;

  assign dig  = is_digit(rx_byte);
  assign dval = dig ? rx_byte[3:0] : 4'd0;
  assign hex  = hex_value(rx_byte);

  // Header match on the first six characters.
  always_comb begin
    kind_next = st.kind;
    if (st.line_pos < HEAD_LEN) begin
      if (st.line_pos < LINE_POS_W'(3)) begin
        if (rx_byte != head_rmc(st.line_pos[2:0])) kind_next = KIND_OTHER;
      end else if (st.line_pos == LINE_POS_W'(3)) begin
        if (st.kind == KIND_NONE) begin
          if (rx_byte == CH_R)      kind_next = KIND_RMC;
          else if (rx_byte == CH_G) kind_next = KIND_GGA;
          else                      kind_next = KIND_OTHER;
        end
      end else if (st.kind == KIND_RMC) begin
        if (rx_byte != head_rmc(st.line_pos[2:0])) kind_next = KIND_OTHER;
      end else if (st.kind == KIND_GGA) begin
        if (rx_byte != head_gga(st.line_pos[2:0])) kind_next = KIND_OTHER;
      end
    end
  end

  // Field value conversions.
  always_comb begin
    full      = st.field_len != 3'd0;
    angle_sum = 35'(st.deg_part) + 35'(st.min_part) * 35'd10000
              + 35'(frac4(st.frac_digits, st.frac_count));
    angle_val = (angle_sum > 35'(ANGLE_MAX)) ? ANGLE_MAX : angle_sum[33:0];
    angle_ok  = !st.stopped && st.dbp >= 4'd3 && st.dbp <= 4'd6 &&
                is_digit(st.first_char);

    case (st.frac_count)
      3'd0:    hund_frac = 7'd0;
      3'd1:    hund_frac = 7'(st.frac_hund * 7'd10);
      default: hund_frac = st.frac_hund;
    endcase
    if (st.negative)                         hund_val = 24'd0;
    else if (st.int_digits > INT_W'(99999))  hund_val = SPD_MAX;
    else hund_val = 24'(st.int_digits[16:0]) * 24'd100 + 24'(hund_frac);

    alt_int = st.negative ? -$signed({1'b0, st.int_digits}) : $signed({1'b0, st.int_digits});
    if (alt_int > 26'sd8388607)       alt_int_sat = ALT_POS;
    else if (alt_int < -26'sd8388608) alt_int_sat = ALT_NEG;
    else                              alt_int_sat = alt_int[23:0];

    alt_ext = {{4{st.alt_val[23]}}, st.alt_val};
    alt_k   = (st.first_char == CH_F) ? 28'sd3 : 28'sd10;
    alt_mul = alt_ext * alt_k;
    if (alt_mul > 28'sd8388607)       alt_mul_sat = ALT_POS;
    else if (alt_mul < -28'sd8388608) alt_mul_sat = ALT_NEG;
    else                              alt_mul_sat = alt_mul[23:0];
  end

  // Field end: store the converted value of the field just closed.
  always_comb begin
    ef_lat    = st.lat_val;
    ef_lon    = st.lon_val;
    ef_alt    = st.alt_val;
    ef_speed  = st.speed_val;
    ef_course = st.course_val;
    ef_date   = st.date_val;
    ef_flags  = st.valid_flags;
    base      = (kind_next == KIND_RMC) ? 5'd3 : 5'd2;
    if (kind_next == KIND_RMC || kind_next == KIND_GGA) begin
      if (st.field_num == base) begin
        ef_flags[0] = angle_ok;
        ef_lat      = angle_val;
      end else if (st.field_num == base + 5'd1) begin
        if (!(full && (st.first_char == CH_N || st.first_char == CH_S))) ef_flags[0] = 1'b0;
        else if (st.first_char == CH_S) ef_lat = -st.lat_val;
      end else if (st.field_num == base + 5'd2) begin
        ef_flags[1] = angle_ok;
        ef_lon      = angle_val;
      end else if (st.field_num == base + 5'd3) begin
        if (!(full && (st.first_char == CH_E || st.first_char == CH_W))) ef_flags[1] = 1'b0;
        else if (st.first_char == CH_W) ef_lon = -st.lon_val;
      end
    end
    if (kind_next == KIND_RMC) begin
      if (st.field_num == 5'd7)      ef_speed  = hund_val;
      else if (st.field_num == 5'd8) ef_course = hund_val;
      else if (st.field_num == 5'd9) begin
        if (st.negative)                          ef_date = 20'd0;
        else if (st.int_digits > INT_W'(DATE_MAX)) ef_date = DATE_MAX;
        else                                      ef_date = st.int_digits[19:0];
      end
    end else if (kind_next == KIND_GGA) begin
      if (st.field_num == 5'd9) begin
        if (full) begin
          ef_alt      = alt_int_sat;
          ef_flags[2] = 1'b1;
        end else begin
          ef_flags[2] = 1'b0;
        end
      end else if (st.field_num == 5'd10) begin
        if (!full) ef_flags[2] = 1'b0;
        else       ef_alt      = alt_mul_sat;
      end
    end
  end

  // Next line state.
  always_comb begin
    st_next  = st;
    int_prod = {4'd0, st.int_digits} * 29'd10 + 29'(dval);
    min_t    = 10'(st.min_part) * 10'd10 + 10'(dval);
    carry    = div100(min_t);
    deg_prod = 37'(st.deg_part) * 37'd10 + 37'(carry) * 37'd600000;
    case (st.field_len[2:1])
      2'd0:    pair_w = 19'd3600;
      2'd1:    pair_w = 19'd60;
      default: pair_w = 19'd1;
    endcase

    if (accept) begin
      if (rx_byte == CH_NL) begin
        st_next = line_clear();
      end else begin
        if (st.line_pos <= LINE_POS_MAX) st_next.line_pos = st.line_pos + 1'b1;
        st_next.kind = kind_next;

        if (!st.star_seen) begin
          if (rx_byte == CH_STAR) begin
            st_next.lat_val     = ef_lat;
            st_next.lon_val     = ef_lon;
            st_next.alt_val     = ef_alt;
            st_next.speed_val   = ef_speed;
            st_next.course_val  = ef_course;
            st_next.date_val    = ef_date;
            st_next.valid_flags = ef_flags;
            st_next.star_seen   = 1'b1;
          end else begin
            if (st.line_pos != '0) st_next.xor_acc = st.xor_acc ^ rx_byte;
            if (rx_byte == CH_COMMA) begin
              st_next = field_clear(st_next);
              st_next.lat_val     = ef_lat;
              st_next.lon_val     = ef_lon;
              st_next.alt_val     = ef_alt;
              st_next.speed_val   = ef_speed;
              st_next.course_val  = ef_course;
              st_next.date_val    = ef_date;
              st_next.valid_flags = ef_flags;
              if (st.field_num < FIELD_LAST) st_next.field_num = st.field_num + 5'd1;
            end else begin
              if (st.field_len == 3'd0) st_next.first_char = rx_byte;
              // time of day from digit pairs of the first field
              if (st.field_num == 5'd1 && st.field_len < 3'd6) begin
                if (!st.field_len[0]) begin
                  if (dig) begin
                    st_next.time_val   = st.time_val + 19'(dval) * pair_w;
                    st_next.pair_first = dval;
                  end else begin
                    st_next.pair_first = PAIR_NONE;
                  end
                end else if (dig && st.pair_first < 4'd10) begin
                  st_next.time_val = st.time_val +
                    (19'(st.pair_first) * 19'd9 + 19'(dval)) * pair_w;
                end
              end
              if (!st.stopped) begin
                if (st.field_len == 3'd0 && (rx_byte == CH_MINUS || rx_byte == CH_PLUS)) begin
                  st_next.negative = (rx_byte == CH_MINUS);
                end else if (dig) begin
                  if (!st.point_seen) begin
                    st_next.int_digits = (int_prod > 29'(INT_CAP)) ? INT_CAP
                                                                   : int_prod[INT_W-1:0];
                    if (st.dbp < DBP_LAST) st_next.dbp = st.dbp + 4'd1;
                    st_next.min_part = 7'(min_t - 10'(carry) * 10'd100);
                    st_next.deg_part = (deg_prod > 37'(ANGLE_SAT)) ? ANGLE_SAT
                                                                   : deg_prod[33:0];
                  end else if (st.frac_count < 3'd4) begin
                    st_next.frac_digits = 14'(st.frac_digits * 14'd10 + 14'(dval));
                    if (st.frac_count < 3'd2)
                      st_next.frac_hund = 7'(st.frac_hund * 7'd10 + 7'(dval));
                    st_next.frac_count = st.frac_count + 3'd1;
                  end
                end else if (rx_byte == CH_DOT && !st.point_seen) begin
                  st_next.point_seen = 1'b1;
                end else begin
                  st_next.stopped = 1'b1;
                end
              end
              if (st.field_len < LEN_LAST) st_next.field_len = st.field_len + 3'd1;
            end
          end
        end else if (st.star_digits < STAR_DONE) begin
          if (!hex[4]) begin
            st_next.star_digits = STAR_BAD;
          end else begin
            st_next.chk_rx      = {st.chk_rx[3:0], hex[3:0]};
            st_next.star_digits = st.star_digits + 2'd1;
          end
        end
      end
    end
  end

  // Result assembled from the state before the newline.
  always_comb begin
    type_ok = st.line_pos >= HEAD_LEN && st.line_pos <= LINE_POS_MAX &&
              (st.kind == KIND_RMC || st.kind == KIND_GGA);
    chk_ok  = type_ok && st.star_seen && st.star_digits == STAR_DONE &&
              st.chk_rx == st.xor_acc;
    rbase   = (st.kind == KIND_RMC) ? 5'd3 : 5'd2;
    res     = '0;
    res.sentence_type = type_ok ? st.kind : KIND_NONE;
    if (chk_ok) begin
      res.checksum_ok   = 1'b1;
      res.time_of_day_s = st.time_val;
      res.lat_valid     = st.valid_flags[0] && st.field_num >= rbase + 5'd1;
      res.lon_valid     = st.valid_flags[1] && st.field_num >= rbase + 5'd3;
      res.alt_valid     = st.kind == KIND_GGA && st.valid_flags[2] && st.field_num >= 5'd10;
      res.latitude      = res.lat_valid ? st.lat_val : '0;
      res.longitude     = res.lon_valid ? st.lon_val : '0;
      res.altitude_dm   = res.alt_valid ? st.alt_val : '0;
      if (st.kind == KIND_RMC) begin
        res.date_ddmmyy      = st.date_val;
        res.speed_centiknots = st.speed_val;
        res.course_centideg  = st.course_val;
      end
    end
  end

  assign res_valid = accept && (rx_byte == CH_NL);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= line_clear();
    end else begin
      st <= st_next;
    end
  end

endmodule

// ----- rtl/nmps_result_reg.sv -----
// Output register holding one parsed result until the downstream takes it.
// Depends on nmps_pkg.
module nmps_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  nmps_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output nmps_pkg::result_t out_res,
  output logic              in_ready
);
  import nmps_pkg::*;

  // Take a new byte whenever the slot is empty or being drained.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

// ----- rtl/nmea_position_sentence_parser_core.sv -----
// NMEA RMC/GGA position sentence parser, top level.
// Depends on nmps_pkg, nmps_line_parser and nmps_result_reg.
//
// Usage:
//   s_* carries the serial text, one ASCII byte per transfer in s_tdata.
//   m_* carries one result per received newline (0x0A); other bytes give none.
//   m_tuser holds the sentence type (0 other/invalid, 1 RMC, 2 GGA).
// Throughput: one byte per cycle while s_tready is high; each byte is parsed
//   by a single pass of logic from the line state registers into those registers.
// Latency: the result is valid on m_* the cycle after the newline transfer.
// Stall: the single output register keeps its result while m_tready is low;
//   s_tready drops only while that register is full and not being drained,
//   so bytes keep flowing up to and through the next newline otherwise.
// Reset: rst clears the line state and empties the output register; the
//   block takes bytes as soon as rst is released, with no clearing pass.
// Lines longer than 128 bytes report type 0.
`include "nmea_position_sentence_parser_core_defines.svh"

module nmea_position_sentence_parser_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // rx_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // checksum_ok, time_of_day_s, date_ddmmyy, latitude, longitude, altitude_dm,
  // speed_centiknots, course_centideg, lat_valid, lon_valid, alt_valid, pad
  output logic [nmps_pkg::DATA_W-1:0] m_tdata,
  output logic [nmps_pkg::USER_W-1:0] m_tuser    // sentence_type
);
  import nmps_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign accept = s_tvalid && s_tready;

  nmps_line_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  nmps_result_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .in_ready  (s_tready)
  );

  assign m_tuser = out_res.sentence_type;
  assign m_tdata = {1'b0,
                    out_res.alt_valid,
                    out_res.lon_valid,
                    out_res.lat_valid,
                    out_res.course_centideg,
                    out_res.speed_centiknots,
                    out_res.altitude_dm,
                    out_res.longitude,
                    out_res.latitude,
                    out_res.date_ddmmyy,
                    out_res.time_of_day_s,
                    out_res.checksum_ok};

  `NMPS_ASSERT_NOW(a_no_accept_when_full, m_tvalid && !m_tready, !s_tready,
    "byte accepted while result register full")
  `NMPS_ASSERT_NEXT(a_newline_gives_result, s_tvalid && s_tready && s_tdata == CH_NL,
    m_tvalid, "newline transfer produced no result")
  `NMPS_ASSERT_NOW(a_bad_type_no_checksum, m_tvalid && m_tuser == KIND_NONE,
    !m_tdata[0], "checksum_ok set for an unrecognised line")
  `NMPS_ASSERT_NOW(a_failed_line_zero, m_tvalid && !m_tdata[0],
    m_tdata[DATA_W-1:1] == '0, "failed line carries nonzero fields")

endmodule
